/* src/gscf_pkg.sv */
// Shared types, constants and helper functions for the gas sensor command framer.
package gscf_pkg;

    localparam int REQ_W    = 2;
    localparam int TEMP_W   = 8;
    localparam int RH_W     = 7;
    localparam int BYTE_W   = 8;
    localparam int WORD_W   = 16;
    localparam int IDX_W    = 3;

    localparam logic [REQ_W-1:0] REQ_MEASURE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_COND    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_SLEEP   = 2'd2;

    localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;
    localparam logic [BYTE_W-1:0] CRC_INIT = 8'hFF;

    localparam logic [TEMP_W-1:0] TEMP_DEFAULT = 8'd50;
    localparam logic [TEMP_W-1:0] TEMP_MAX     = 8'd130;
    localparam logic [TEMP_W-1:0] TEMP_OFFSET  = 8'd45;
    localparam logic [RH_W-1:0]   RH_DEFAULT   = 7'd25;
    localparam logic [RH_W-1:0]   RH_MAX       = 7'd100;

    // ceil(65535 * 2^16 / span): the upper 16 bits of the product give the truncated quotient
    localparam int PROD_W = 33;
    localparam int SCALE_SHIFT = 16;
    localparam logic [PROD_W-1:0] RH_MULT   = 33'd42949018;
    localparam logic [PROD_W-1:0] TEMP_MULT = 33'd24542296;

    localparam logic [BYTE_W-1:0] CMD_HI        = 8'h26;
    localparam logic [BYTE_W-1:0] CMD_MEASURE   = 8'h19;
    localparam logic [BYTE_W-1:0] SLEEP_HI      = 8'h36;
    localparam logic [BYTE_W-1:0] SLEEP_LO      = 8'h15;

    typedef struct packed {
        logic [REQ_W-1:0]  kind;
        logic [WORD_W-1:0] hum_word;
        logic [WORD_W-1:0] temp_word;
    } t_frame;

    function automatic logic [BYTE_W-1:0] crc_byte(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] r;
        r = c;
        for (int b = 0; b < BYTE_W; b++) begin
            if (r[BYTE_W-1]) begin
                r = {r[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                r = {r[BYTE_W-2:0], 1'b0};
            end
        end
        return r;
    endfunction

    function automatic logic [BYTE_W-1:0] cond_byte(input logic [IDX_W-1:0] idx);
        logic [BYTE_W-1:0] r;
        r = 8'h00;
        case (idx)
            3'd0: r = 8'h26;
            3'd1: r = 8'h12;
            3'd2: r = 8'h80;
            3'd3: r = 8'h00;
            3'd4: r = 8'hA2;
            3'd5: r = 8'h66;
            3'd6: r = 8'h66;
            3'd7: r = 8'h93;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

/* src/gscf_if.sv */
// Valid/ready channels for requests and frame bytes.
interface gscf_req_if import gscf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [REQ_W-1:0]  req_type;
    logic [TEMP_W-1:0] temperature_c;
    logic [RH_W-1:0]   humidity_pct;

    modport source (output valid, output req_type, output temperature_c,
                    output humidity_pct, input ready);
    modport sink   (input valid, input req_type, input temperature_c,
                    input humidity_pct, output ready);
endinterface

interface gscf_byte_if import gscf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] frame_byte;
    logic              last_byte;

    modport source (output valid, output frame_byte, output last_byte, input ready);
    modport sink   (input valid, input frame_byte, input last_byte, output ready);
endinterface

/* src/gscf_front.sv */
// Front end: takes requests, applies defaults and clamps, scales the measure words.
module gscf_front import gscf_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    gscf_req_if.sink     i_req,
    output logic         o_push_vld,
    output t_frame       o_push_data,
    input  logic         i_push_rdy
);

    logic              r_vld;
    logic [REQ_W-1:0]  r_kind;
    logic [TEMP_W-1:0] r_temp;
    logic [RH_W-1:0]   r_rh;

    logic              drop;
    logic              advance;
    logic [TEMP_W-1:0] temp_c;
    logic [RH_W-1:0]   rh_c;
    logic [TEMP_W-1:0] temp_ofs;
    logic [PROD_W-1:0] hum_prod;
    logic [PROD_W-1:0] temp_prod;

    always_comb begin
        if (r_temp == '0) begin
            temp_c = TEMP_DEFAULT;
        end else if (r_temp > TEMP_MAX) begin
            temp_c = TEMP_MAX;
        end else begin
            temp_c = r_temp;
        end
        if (r_rh == '0) begin
            rh_c = RH_DEFAULT;
        end else if (r_rh > RH_MAX) begin
            rh_c = RH_MAX;
        end else begin
            rh_c = r_rh;
        end
        temp_ofs  = temp_c + TEMP_OFFSET;
        hum_prod  = PROD_W'(rh_c) * RH_MULT;
        temp_prod = PROD_W'(temp_ofs) * TEMP_MULT;
    end

    assign drop       = (r_kind != REQ_MEASURE) && (r_kind != REQ_COND) && (r_kind != REQ_SLEEP);
    assign o_push_vld = r_vld && !drop;
    assign advance    = !r_vld || drop || i_push_rdy;
    assign i_req.ready = advance;

    assign o_push_data.kind      = r_kind;
    assign o_push_data.hum_word  = hum_prod[SCALE_SHIFT +: WORD_W];
    assign o_push_data.temp_word = temp_prod[SCALE_SHIFT +: WORD_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (advance) begin
            r_vld <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && i_req.valid) begin
            r_kind <= i_req.req_type;
            r_temp <= i_req.temperature_c;
            r_rh   <= i_req.humidity_pct;
        end
    end

endmodule

/* src/gscf_queue.sv */
// Two-entry queue between the front end and the byte sequencer.
module gscf_queue import gscf_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push_vld,
    input  t_frame i_push_data,
    output logic   o_push_rdy,
    output logic   o_head_vld,
    output t_frame o_head,
    input  logic   i_pop
);

    t_frame     r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    logic push;
    logic pop;

    assign o_push_rdy = (r_count != 2'd2);
    assign o_head_vld = (r_count != 2'd0);
    assign o_head     = r_mem[r_rd_ptr];
    assign push       = i_push_vld && o_push_rdy;
    assign pop        = i_pop && o_head_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (push && !pop) begin
                r_count <= r_count + 2'd1;
            end else if (pop && !push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

/* src/gscf_back.sv */
// Byte sequencer: walks the head frame, computes the CRC bytes, drives the output register.
module gscf_back import gscf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_head_vld,
    input  t_frame      i_head,
    output logic        o_pop,
    gscf_byte_if.source o_frame
);

    logic [IDX_W-1:0]  r_idx;
    logic [BYTE_W-1:0] r_crc;
    logic              r_out_vld;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_last;

    logic [BYTE_W-1:0] sel_byte;
    logic              sel_last;
    logic              load;
    logic              crc_start;
    logic              crc_cont;

    always_comb begin
        sel_byte  = '0;
        sel_last  = 1'b0;
        crc_start = 1'b0;
        crc_cont  = 1'b0;
        unique case (i_head.kind)
            REQ_MEASURE: begin
                sel_last = (r_idx == 3'd7);
                unique case (r_idx)
                    3'd0: sel_byte = CMD_HI;
                    3'd1: sel_byte = CMD_MEASURE;
                    3'd2: begin
                        sel_byte  = i_head.hum_word[WORD_W-1 -: BYTE_W];
                        crc_start = 1'b1;
                    end
                    3'd3: begin
                        sel_byte = i_head.hum_word[BYTE_W-1:0];
                        crc_cont = 1'b1;
                    end
                    3'd4: sel_byte = r_crc;
                    3'd5: begin
                        sel_byte  = i_head.temp_word[WORD_W-1 -: BYTE_W];
                        crc_start = 1'b1;
                    end
                    3'd6: begin
                        sel_byte = i_head.temp_word[BYTE_W-1:0];
                        crc_cont = 1'b1;
                    end
                    3'd7: sel_byte = r_crc;
                    default: sel_byte = '0;
                endcase
            end
            REQ_COND: begin
                sel_byte = cond_byte(r_idx);
                sel_last = (r_idx == 3'd7);
            end
            REQ_SLEEP: begin
                sel_byte = (r_idx == 3'd0) ? SLEEP_HI : SLEEP_LO;
                sel_last = (r_idx == 3'd1);
            end
            default: begin
                sel_byte = '0;
                sel_last = 1'b1;
            end
        endcase
    end

    assign load  = i_head_vld && (!r_out_vld || o_frame.ready);
    assign o_pop = load && sel_last;

    assign o_frame.valid      = r_out_vld;
    assign o_frame.frame_byte = r_out_byte;
    assign o_frame.last_byte  = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_idx     <= '0;
        end else begin
            if (load) begin
                r_out_vld <= 1'b1;
                r_idx     <= sel_last ? '0 : r_idx + 3'd1;
            end else if (o_frame.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_byte <= sel_byte;
            r_out_last <= sel_last;
            if (crc_start) begin
                r_crc <= crc_byte(CRC_INIT ^ sel_byte);
            end else if (crc_cont) begin
                r_crc <= crc_byte(r_crc ^ sel_byte);
            end
        end
    end

endmodule

/* src/gas_sensor_command_framer.sv */
// Top level of the gas sensor command framer.
// Usage:
//   i_req takes one request word: req_type, temperature_c, humidity_pct.
//   o_frame gives the command bytes in transmit order, one per word, with
//   last_byte set on the final byte of each frame.
//   Measure and conditioning requests give 8 bytes, sleep gives 2, and the
//   unused request code gives none.
// A request passes through the front end's intake register, the queue and
//   the output register before its first byte is valid.
// Throughput: one byte per cycle while a frame is queued and the receiver
//   is ready; the output register's load condition sets this rate.
// A two-frame queue decouples request intake from byte output: requests are
//   still taken while the receiver stalls, until the queue and the intake
//   register fill, then i_req.ready drops.
// A stalled output word holds its byte and last flag until taken.
// Reset (synchronous, active low) empties the queue and the output register;
//   no frame in flight survives it.
module gas_sensor_command_framer import gscf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gscf_req_if.sink    i_req,
    gscf_byte_if.source o_frame
);

    logic   push_vld;
    logic   push_rdy;
    t_frame push_data;
    logic   head_vld;
    t_frame head;
    logic   pop;

    gscf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_push_vld  (push_vld),
        .o_push_data (push_data),
        .i_push_rdy  (push_rdy)
    );

    gscf_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push_vld  (push_vld),
        .i_push_data (push_data),
        .o_push_rdy  (push_rdy),
        .o_head_vld  (head_vld),
        .o_head      (head),
        .i_pop       (pop)
    );

    gscf_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head_vld (head_vld),
        .i_head     (head),
        .o_pop      (pop),
        .o_frame    (o_frame)
    );

endmodule
